FILE: rtl/sms_pkg.sv
// Shared constants, types and state encodings of the stable merge sorter.
`default_nettype none

package sms_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W     = CNT_W + 1;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SORT,
        S_EMIT
    } sms_state_t;

    typedef enum logic [1:0] {
        M_IDLE,
        M_SEG,
        M_MERGE
    } sms_mstate_t;

    // Memory requests issued by the merge sequencer.
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr0;
        logic [IDX_W-1:0]  raddr1;
    } sms_mem_req_t;

    // Sequencer status; bank is the source bank (the result bank once idle).
    typedef struct packed {
        logic busy;
        logic done;
        logic bank;
    } sms_sort_stat_t;

endpackage

`default_nettype wire

FILE: rtl/sms_if.sv
// Valid/ready stream interfaces for the sorter's input and result channels.
`default_nettype none

interface sms_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [sms_pkg::DATA_W-1:0]  value;
    logic                               last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface sms_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [sms_pkg::DATA_W-1:0]  sorted_value;
    logic                               end_of_list;
    logic                               dropped;

    modport source (output valid, output sorted_value, output end_of_list, output dropped,
                    input ready);
    modport sink   (input valid, input sorted_value, input end_of_list, input dropped,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/stable_merge_sorter_top.sv
// Top level of the stable merge sorter: load, sort and emit around two RAM banks.
//
// Usage:
//   items   : input stream, one signed 32-bit value per beat; last closes a list.
//   results : output stream, sorted ascending, equal keys in load order;
//             end_of_list marks the final beat, dropped is set on every beat of a
//             list that lost items beyond the MAX_ITEMS capacity.
// Phases, for a list of n stored items:
//   load    : items.ready high while loading; a beat is taken whenever valid.
//   sort    : a start step, then ceil(log2 n) passes, each paced by the single
//             write port of the merge bank: one element per cycle plus one
//             head-fetch step (M_SEG) per segment.
//   emit    : each result beat is read from the result bank through its
//             registered read port into the output register; a new read is
//             issued only once the previous read has returned.
//   A list of one item skips the merge passes.
// Reset clears the state machines, top-level counters and output valid; RAM contents are
// not cleared and need no clearing pass. A stalled receiver holds the beat in
// the output register and pauses the emission; once the final read is issued
// the block takes the next list while that beat still waits.
`default_nettype none

module stable_merge_sorter_top (
    input  wire logic clk,
    input  wire logic rst_n,
    sms_in_if.sink    items,
    sms_out_if.source results
);

    sms_pkg::sms_state_t state_reg, state_next;

    // list bookkeeping
    logic [sms_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      ovf_reg, ovf_next;
    logic [sms_pkg::CNT_W-1:0] n_reg, n_next;
    logic                      drop_reg, drop_next;
    logic                      start_reg, start_next;

    // emission
    logic [sms_pkg::CNT_W-1:0] emit_idx_reg, emit_idx_next;
    logic                      pend_reg, pend_next;
    logic                      pend_last_reg, pend_last_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic [sms_pkg::DATA_W-1:0] out_data_reg;
    logic                       out_last_reg;
    logic                       out_drop_reg;

    logic                      acc;
    logic                      has_room;
    logic [sms_pkg::CNT_W-1:0] count_plus;
    logic                      issue;

    // RAM ports
    logic                       we_a, we_b;
    logic [sms_pkg::IDX_W-1:0]  waddr, raddr0, raddr1;
    logic [sms_pkg::DATA_W-1:0] wdata;
    logic [sms_pkg::DATA_W-1:0] rda0, rda1, rdb0, rdb1, rd0_sel, rd1_sel;

    sms_pkg::sms_mem_req_t   mreq;
    sms_pkg::sms_sort_stat_t mstat;

    sms_ram #(.DEPTH(sms_pkg::MAX_ITEMS), .WIDTH(sms_pkg::DATA_W)) u_bank_a (
        .clk    (clk),
        .we     (we_a),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rda0),
        .rdata1 (rda1)
    );

    sms_ram #(.DEPTH(sms_pkg::MAX_ITEMS), .WIDTH(sms_pkg::DATA_W)) u_bank_b (
        .clk    (clk),
        .we     (we_b),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdb0),
        .rdata1 (rdb1)
    );

    sms_merger u_merger (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .n     (n_reg),
        .rd0   (rd0_sel),
        .rd1   (rd1_sel),
        .req   (mreq),
        .stat  (mstat)
    );

    // source bank while sorting, result bank once the sequencer is idle
    assign rd0_sel = mstat.bank ? rdb0 : rda0;
    assign rd1_sel = mstat.bank ? rdb1 : rda1;

    assign items.ready          = (state_reg == sms_pkg::S_LOAD);
    assign results.valid        = out_valid_reg;
    assign results.sorted_value = out_data_reg;
    assign results.end_of_list  = out_last_reg;
    assign results.dropped      = out_drop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sms_pkg::S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            n_reg         <= '0;
            drop_reg      <= 1'b0;
            start_reg     <= 1'b0;
            emit_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            n_reg         <= n_next;
            drop_reg      <= drop_next;
            start_reg     <= start_next;
            emit_idx_reg  <= emit_idx_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload, loaded when the pending read returns
    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            out_data_reg <= rd0_sel;
            out_last_reg <= pend_last_reg;
            out_drop_reg <= drop_reg;
        end
    end

    always_comb
    begin
        acc        = items.valid && items.ready;
        has_room   = (count_reg != sms_pkg::CNT_W'(sms_pkg::MAX_ITEMS));
        count_plus = count_reg + sms_pkg::CNT_W'(1);

        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        n_next         = n_reg;
        drop_next      = drop_reg;
        start_next     = 1'b0;
        emit_idx_next  = emit_idx_reg;
        pend_last_next = pend_last_reg;
        issue          = 1'b0;

        case (state_reg)
            sms_pkg::S_LOAD:
            begin
                if (acc)
                begin
                    if (has_room)
                    begin
                        count_next = count_plus;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (items.last)
                    begin
                        n_next     = has_room ? count_plus : count_reg;
                        drop_next  = ovf_reg || !has_room;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        start_next = 1'b1;
                        state_next = sms_pkg::S_SORT;
                    end
                end
            end
            sms_pkg::S_SORT:
            begin
                if (mstat.done)
                begin
                    emit_idx_next = '0;
                    state_next    = sms_pkg::S_EMIT;
                end
            end
            sms_pkg::S_EMIT:
            begin
                // read only when the output register is free by the time data returns
                issue = !pend_reg && (!out_valid_reg || results.ready);
                if (issue)
                begin
                    emit_idx_next  = emit_idx_reg + sms_pkg::CNT_W'(1);
                    pend_last_next = (emit_idx_next == n_reg);
                    if (emit_idx_next == n_reg)
                    begin
                        state_next = sms_pkg::S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = sms_pkg::S_LOAD;
            end
        endcase

        pend_next = issue;

        if (pend_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        // RAM port steering
        if (state_reg == sms_pkg::S_LOAD)
        begin
            we_a  = acc && has_room;
            we_b  = 1'b0;
            waddr = count_reg[sms_pkg::IDX_W-1:0];
            wdata = items.value;
        end
        else
        begin
            we_a  = mreq.we && mstat.bank;
            we_b  = mreq.we && !mstat.bank;
            waddr = mreq.waddr;
            wdata = mreq.wdata;
        end
        raddr0 = (state_reg == sms_pkg::S_EMIT) ? emit_idx_reg[sms_pkg::IDX_W-1:0]
                                                : mreq.raddr0;
        raddr1 = mreq.raddr1;
    end

    a_merge_writes_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
        mreq.we |-> (state_reg == sms_pkg::S_SORT))
        else $error("merge write outside the sort phase");

    a_pend_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |=> out_valid_reg)
        else $error("returned read data did not reach the output register");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !out_valid_reg || $past(results.ready))
        else $error("output beat overwritten before it was taken");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sms_pkg::S_EMIT) |-> (emit_idx_reg < n_reg) && !mstat.busy)
        else $error("emission index past the list or sequencer still busy");

    a_list_size: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sms_pkg::S_SORT) |->
            (n_reg != '0) && (n_reg <= sms_pkg::CNT_W'(sms_pkg::MAX_ITEMS)))
        else $error("sorting a list of impossible size");

endmodule

`default_nettype wire

FILE: rtl/sms_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
`default_nettype none

module sms_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr0,
    input  wire logic [AW-1:0]    raddr1,
    output logic      [WIDTH-1:0] rdata0,
    output logic      [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

`default_nettype wire

FILE: rtl/sms_merger.sv
// Bottom-up merge sequencer: ping-pongs passes of run merges between two banks.
`default_nettype none

module sms_merger (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [sms_pkg::CNT_W-1:0]   n,
    input  wire logic [sms_pkg::DATA_W-1:0]  rd0,
    input  wire logic [sms_pkg::DATA_W-1:0]  rd1,
    output sms_pkg::sms_mem_req_t            req,
    output sms_pkg::sms_sort_stat_t          stat
);

    sms_pkg::sms_mstate_t state_reg, state_next;
    logic [sms_pkg::CNT_W-1:0] width_reg, width_next;
    logic [sms_pkg::CNT_W-1:0] lo_reg, lo_next;
    logic [sms_pkg::CNT_W-1:0] mid_reg, mid_next;
    logic [sms_pkg::CNT_W-1:0] hi_reg, hi_next;
    logic [sms_pkg::CNT_W-1:0] a_reg, a_next;
    logic [sms_pkg::CNT_W-1:0] b_reg, b_next;
    logic [sms_pkg::CNT_W-1:0] k_reg, k_next;
    logic                      src_reg, src_next;

    logic [sms_pkg::SUM_W-1:0] n_s, lo_w, lo_2w, w2;
    logic                      take_b;
    logic                      done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sms_pkg::M_IDLE;
            src_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            src_reg   <= src_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg <= width_next;
        lo_reg    <= lo_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        k_reg     <= k_next;
    end

    always_comb
    begin
        n_s   = {1'b0, n};
        lo_w  = {1'b0, lo_reg} + {1'b0, width_reg};
        lo_2w = lo_w + {1'b0, width_reg};
        w2    = {width_reg, 1'b0};
        // ties go to the left run
        take_b = (a_reg >= mid_reg) ||
                 ((b_reg < hi_reg) && ($signed(rd0) > $signed(rd1)));

        state_next = state_reg;
        width_next = width_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        src_next   = src_reg;
        done       = 1'b0;
        req.we     = 1'b0;
        req.waddr  = k_reg[sms_pkg::IDX_W-1:0];
        req.wdata  = take_b ? rd1 : rd0;

        case (state_reg)
            sms_pkg::M_IDLE:
            begin
                if (start)
                begin
                    width_next = sms_pkg::CNT_W'(1);
                    lo_next    = '0;
                    src_next   = 1'b0;
                    if (n > sms_pkg::CNT_W'(1))
                    begin
                        state_next = sms_pkg::M_SEG;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
            end
            sms_pkg::M_SEG:
            begin
                mid_next   = (lo_w > n_s) ? n : lo_w[sms_pkg::CNT_W-1:0];
                hi_next    = (lo_2w > n_s) ? n : lo_2w[sms_pkg::CNT_W-1:0];
                a_next     = lo_reg;
                b_next     = mid_next;
                k_next     = lo_reg;
                state_next = sms_pkg::M_MERGE;
            end
            sms_pkg::M_MERGE:
            begin
                req.we = 1'b1;
                k_next = k_reg + sms_pkg::CNT_W'(1);
                if (take_b)
                begin
                    b_next = b_reg + sms_pkg::CNT_W'(1);
                end
                else
                begin
                    a_next = a_reg + sms_pkg::CNT_W'(1);
                end
                if (k_next == hi_reg)
                begin
                    if (lo_2w >= n_s)
                    begin
                        // pass complete: swap banks, double the run width
                        src_next   = ~src_reg;
                        width_next = w2[sms_pkg::CNT_W-1:0];
                        lo_next    = '0;
                        if (w2 >= n_s)
                        begin
                            state_next = sms_pkg::M_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            state_next = sms_pkg::M_SEG;
                        end
                    end
                    else
                    begin
                        lo_next    = lo_2w[sms_pkg::CNT_W-1:0];
                        state_next = sms_pkg::M_SEG;
                    end
                end
            end
            default:
            begin
                state_next = sms_pkg::M_IDLE;
            end
        endcase

        // run heads are fetched in the cycle before the compare uses them
        req.raddr0 = a_next[sms_pkg::IDX_W-1:0];
        req.raddr1 = b_next[sms_pkg::IDX_W-1:0];

        stat.busy = (state_reg != sms_pkg::M_IDLE);
        stat.done = done;
        stat.bank = src_reg;
    end

    // output index stays inside the segment being merged
    a_k_in_seg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sms_pkg::M_MERGE) |-> (k_reg >= lo_reg) && (k_reg < hi_reg))
        else $error("merge write index left its segment");

    a_heads_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sms_pkg::M_MERGE) |->
            ({1'b0, a_reg} - {1'b0, lo_reg}) + ({1'b0, b_reg} - {1'b0, mid_reg})
            == ({1'b0, k_reg} - {1'b0, lo_reg}))
        else $error("run heads out of step with the write index");

    a_b_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sms_pkg::M_MERGE) |-> (a_reg <= mid_reg) && (b_reg <= hi_reg))
        else $error("run head past its run");

endmodule

`default_nettype wire
